FILE: hw/rtl/ping_history_rtt_loss_jitter_core_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef PING_HISTORY_RTT_LOSS_JITTER_CORE_ASSERT_SVH
`define PING_HISTORY_RTT_LOSS_JITTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PHRLJ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PHRLJ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/phrlj_pkg.sv
`default_nettype none
package phrlj_pkg;

  localparam int TIME_W = 48;
  localparam int SEQ_W  = 64;
  localparam int LOSS_W = 14;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PING  = 2'd1;
  localparam logic [1:0] OP_PONG  = 2'd2;
  localparam logic [1:0] OP_STATS = 2'd3;

  localparam logic KIND_SEQ   = 1'b0;
  localparam logic KIND_STATS = 1'b1;

  localparam logic [LOSS_W-1:0] LOSS_FULL = 14'd10000;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] sent_time;
    logic              sent_valid;
    logic [TIME_W-1:0] pong_time;
    logic              pong_valid;
  } slot_t;

  localparam slot_t SLOT_RESET = '{seq: '1, sent_time: '0, sent_valid: 1'b0,
                                   pong_time: '0, pong_valid: 1'b0};

endpackage
`default_nettype wire

FILE: hw/rtl/ping_history_rtt_loss_jitter_core.sv
`default_nettype none
// Channel   Direction  Handshake              Contents
// request   in         in_valid / in_stall    opcode, event_time, pong_sequence, window
// result    out        out_valid / out_stall  kind, sequence, min rtt, jitter, loss
// config    in         cfg_valid / cfg_ready  loss_safety_margin
//
// A ping writes its slot; a pong reduces the sequence modulo HISTORY_DEPTH, eight bits
// a cycle by compare and subtract, then reads its slot and writes it if the slot still
// holds that sequence; stats make two ring scans, one slot per cycle through the
// memory's read port, then up to two divisions.
// Clear and reset sweep the ring with requests stalled.
// A finished result waits in the output register while the next request is taken.
module ping_history_rtt_loss_jitter_core import phrlj_pkg::*; #(
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        opcode,
  input  wire logic [TIME_W-1:0] event_time,
  input  wire logic [SEQ_W-1:0]  pong_sequence,
  input  wire logic [TIME_W-1:0] window_start,
  input  wire logic [TIME_W-1:0] window_end,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   result_kind,
  output logic [SEQ_W-1:0]       assigned_sequence,
  output logic [TIME_W-1:0]      min_rtt_us,
  output logic                   rtt_valid,
  output logic [TIME_W-1:0]      jitter_us,
  output logic [LOSS_W-1:0]      loss_hundredths,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [TIME_W-1:0] cfg_data
);

  localparam int AW         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW         = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W      = TIME_W + CW;
  localparam int LNUM_W     = LOSS_W + CW;
  localparam int MOD_STEP   = 8;
  localparam int MOD_CYCLES = SEQ_W / MOD_STEP;
  localparam int MOD_CW     = $clog2(MOD_CYCLES);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_PONG_MOD = 4'd2;
  localparam logic [3:0] S_PONG_RD  = 4'd3;
  localparam logic [3:0] S_PONG_WR  = 4'd4;
  localparam logic [3:0] S_SCAN1    = 4'd5;
  localparam logic [3:0] S_SCAN2    = 4'd6;
  localparam logic [3:0] S_JIT_DIV  = 4'd7;
  localparam logic [3:0] S_LOSS_GO  = 4'd8;
  localparam logic [3:0] S_LOSS_DIV = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]        state;
  logic [AW-1:0]     clr_idx;
  logic [TIME_W-1:0] margin;
  logic [SEQ_W-1:0]  next_seq;
  logic [AW-1:0]     next_slot;

  logic [TIME_W-1:0] req_time;
  logic [SEQ_W-1:0]  req_seq;
  logic [TIME_W-1:0] req_start;
  logic [TIME_W-1:0] req_end;
  logic              loss_open;
  logic [TIME_W-1:0] loss_end;
  logic [AW-1:0]     slot_idx;

  logic [SEQ_W-1:0]  mod_shift;
  logic [AW-1:0]     mod_rem;
  logic [AW-1:0]     mod_rem_next;
  logic [AW:0]       mod_trial;
  logic [MOD_CW-1:0] mod_cnt;

  logic [AW:0]       scan_idx;
  logic              proc_v;
  logic [CW-1:0]     pings;
  logic [CW-1:0]     pongs;
  logic [CW-1:0]     samples;
  logic [TIME_W-1:0] min_rtt;
  logic              have_rtt;
  logic [SUM_W-1:0]  sum;
  logic [TIME_W-1:0] jitter;
  logic [LOSS_W-1:0] loss;
  logic [LNUM_W-1:0] loss_num;
  logic              res_kind;
  logic [SEQ_W-1:0]  res_seq;

  logic              div_go;
  logic [SEQ_W-1:0]  div_num;
  logic [CW-1:0]     div_den;
  logic              div_done;
  logic [SEQ_W-1:0]  div_quot;

  slot_t             mem [HISTORY_DEPTH];
  slot_t             rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  slot_t             mem_wdata;
  logic [AW-1:0]     mem_raddr;

  logic              accept;
  logic              out_free;
  logic              scan_end;
  logic              sent_ok;
  logic              cnt_ping;
  logic              cnt_pong;
  logic              rtt_ok;
  logic [TIME_W-1:0] rtt;

  assign in_stall  = rst || (state != S_IDLE);
  assign cfg_ready = !rst;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign scan_end  = (scan_idx == (AW+1)'(HISTORY_DEPTH)) && !proc_v;

  // Per-slot window tests on the registered read data.
  assign sent_ok  = rdata.sent_valid && (rdata.sent_time >= req_start);
  assign cnt_ping = sent_ok && loss_open && (rdata.sent_time <= loss_end);
  assign cnt_pong = cnt_ping && rdata.pong_valid && (rdata.pong_time >= rdata.sent_time);
  assign rtt_ok   = sent_ok && (rdata.sent_time <= req_end) && rdata.pong_valid &&
                    (rdata.pong_time > rdata.sent_time);
  assign rtt      = rdata.pong_time - rdata.sent_time;

  assign loss_num = LNUM_W'(LOSS_FULL) * LNUM_W'(pings - pongs);

  // Eight remainder steps a cycle; the running remainder always stays below the depth.
  always_comb begin
    mod_rem_next = mod_rem;
    mod_trial    = '0;
    for (int k = 0; k < MOD_STEP; k++) begin
      mod_trial = {mod_rem_next, mod_shift[SEQ_W-1-k]};
      if (mod_trial >= (AW+1)'(HISTORY_DEPTH)) begin
        mod_rem_next = AW'(mod_trial - (AW+1)'(HISTORY_DEPTH));
      end else begin
        mod_rem_next = mod_trial[AW-1:0];
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = SLOT_RESET;
    mem_raddr = scan_idx[AW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && opcode == OP_PING) begin
          mem_we    = 1'b1;
          mem_waddr = next_slot;
          mem_wdata = '{seq: next_seq, sent_time: event_time, sent_valid: 1'b1,
                        pong_time: '0, pong_valid: 1'b0};
        end
      end
      S_PONG_RD: begin
        mem_raddr = slot_idx;
      end
      S_PONG_WR: begin
        mem_waddr            = slot_idx;
        mem_wdata            = rdata;
        mem_wdata.pong_time  = req_time;
        mem_wdata.pong_valid = 1'b1;
        mem_we               = (rdata.seq == req_seq);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  phrlj_div #(.DEN_W(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      margin    <= '0;
      next_seq  <= '0;
      next_slot <= '0;
      div_go    <= 1'b0;
      out_valid <= 1'b0;
      proc_v    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        margin <= cfg_data;
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_idx == AW'(HISTORY_DEPTH - 1)) begin
            clr_idx <= '0;
            state   <= S_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_time  <= event_time;
            req_seq   <= pong_sequence;
            req_start <= window_start;
            req_end   <= window_end;
            loss_open <= window_end >= margin;
            loss_end  <= window_end - margin;
            case (opcode)
              OP_CLEAR: begin
                next_seq  <= '0;
                next_slot <= '0;
                clr_idx   <= '0;
                state     <= S_CLEAR;
              end
              OP_PING: begin
                res_kind  <= KIND_SEQ;
                res_seq   <= next_seq;
                next_seq  <= next_seq + 1'b1;
                next_slot <= (next_slot == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                    : next_slot + 1'b1;
                state     <= S_DONE;
              end
              OP_PONG: begin
                mod_shift <= pong_sequence;
                mod_rem   <= '0;
                mod_cnt   <= '0;
                state     <= S_PONG_MOD;
              end
              default: begin
                scan_idx <= '0;
                proc_v   <= 1'b0;
                pings    <= '0;
                pongs    <= '0;
                samples  <= '0;
                sum      <= '0;
                min_rtt  <= '0;
                have_rtt <= 1'b0;
                state    <= S_SCAN1;
              end
            endcase
          end
        end
        S_PONG_MOD: begin
          mod_rem   <= mod_rem_next;
          mod_shift <= mod_shift << MOD_STEP;
          mod_cnt   <= mod_cnt + 1'b1;
          if (mod_cnt == MOD_CW'(MOD_CYCLES - 1)) begin
            slot_idx <= mod_rem_next;
            state    <= S_PONG_RD;
          end
        end
        S_PONG_RD: begin
          state <= S_PONG_WR;
        end
        S_PONG_WR: begin
          state <= S_IDLE;
        end
        S_SCAN1, S_SCAN2: begin
          if (scan_idx != (AW+1)'(HISTORY_DEPTH)) begin
            scan_idx <= scan_idx + 1'b1;
            proc_v   <= 1'b1;
          end else begin
            proc_v <= 1'b0;
          end
          if (proc_v && state == S_SCAN1) begin
            if (cnt_ping) begin
              pings <= pings + 1'b1;
            end
            if (cnt_pong) begin
              pongs <= pongs + 1'b1;
            end
            if (rtt_ok && (!have_rtt || rtt < min_rtt)) begin
              min_rtt <= rtt;
            end
            have_rtt <= have_rtt || rtt_ok;
          end
          if (proc_v && state == S_SCAN2 && rtt_ok) begin
            sum     <= sum + SUM_W'(rtt - min_rtt);
            samples <= samples + 1'b1;
          end
          if (scan_end) begin
            scan_idx <= '0;
            if (state == S_SCAN1) begin
              state <= S_SCAN2;
            end else if (samples != '0) begin
              div_go  <= 1'b1;
              div_num <= SEQ_W'(sum);
              div_den <= samples;
              state   <= S_JIT_DIV;
            end else begin
              jitter <= '0;
              state  <= S_LOSS_GO;
            end
          end
        end
        S_JIT_DIV: begin
          div_go <= 1'b0;
          if (div_done) begin
            jitter <= div_quot[TIME_W-1:0];
            state  <= S_LOSS_GO;
          end
        end
        S_LOSS_GO: begin
          if (pings != '0) begin
            div_go  <= 1'b1;
            div_num <= SEQ_W'(loss_num);
            div_den <= pings;
            state   <= S_LOSS_DIV;
          end else begin
            loss  <= LOSS_FULL;
            state <= S_DONE;
          end
          res_kind <= KIND_STATS;
        end
        S_LOSS_DIV: begin
          div_go <= 1'b0;
          if (div_done) begin
            loss  <= div_quot[LOSS_W-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            result_kind       <= res_kind;
            assigned_sequence <= (res_kind == KIND_SEQ) ? res_seq : '0;
            rtt_valid         <= (res_kind == KIND_STATS) && have_rtt;
            min_rtt_us        <= ((res_kind == KIND_STATS) && have_rtt) ? min_rtt : '0;
            jitter_us         <= (res_kind == KIND_STATS) ? jitter : '0;
            loss_hundredths   <= (res_kind == KIND_STATS) ? loss : '0;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/phrlj_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle over a 64-bit numerator.
module phrlj_div import phrlj_pkg::*; #(
  parameter int DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SEQ_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [SEQ_W-1:0]      quot
);

  localparam int CNT_W = $clog2(SEQ_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, quot[SEQ_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (start) begin
        cnt   <= CNT_W'(SEQ_W);
        den_r <= den;
        quot  <= num;
        rem   <= '0;
        done  <= 1'b0;
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        quot <= {quot[SEQ_W-2:0], ge};
        rem  <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        done <= (cnt == CNT_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/phrlj_checker.sv
`default_nettype none
`include "ping_history_rtt_loss_jitter_core_assert.svh"
module phrlj_checker import phrlj_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              result_kind,
  input wire logic [SEQ_W-1:0]  assigned_sequence,
  input wire logic [TIME_W-1:0] min_rtt_us,
  input wire logic              rtt_valid,
  input wire logic [TIME_W-1:0] jitter_us,
  input wire logic [LOSS_W-1:0] loss_hundredths
);

  // A stalled result stays valid and keeps its kind and sequence.
  `PHRLJ_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(result_kind) && $stable(assigned_sequence), "result changed under stall")

  // A sequence result carries no statistics.
  `PHRLJ_ASSERT_NOW(a_seq_clean, out_valid && result_kind == KIND_SEQ,
    min_rtt_us == '0 && !rtt_valid && jitter_us == '0 && loss_hundredths == '0,
    "sequence result has statistics")

  // Without a round trip sample the minimum and jitter are zero.
  `PHRLJ_ASSERT_NOW(a_no_rtt, out_valid && result_kind == KIND_STATS && !rtt_valid,
    min_rtt_us == '0 && jitter_us == '0, "rtt fields set without samples")

  `PHRLJ_ASSERT_NOW(a_loss_range, out_valid,
    loss_hundredths <= LOSS_FULL, "loss above one hundred percent")

endmodule

bind ping_history_rtt_loss_jitter_core phrlj_checker u_phrlj_checker (.*);
`default_nettype wire
